FILE: hdl/gps_time_to_calendar_date_assert.svh
// Assertion macros shared by the GPS time to calendar date RTL.
// Depends on nothing; the assertion forms drop out when SYNTHESIS is defined.
`ifndef GPS_TIME_TO_CALENDAR_DATE_ASSERT_SVH
`define GPS_TIME_TO_CALENDAR_DATE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define GTC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gps_time_to_calendar_date assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define GTC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gps_time_to_calendar_date assertion failed");
`else
`define GTC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define GTC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: hdl/gtc_pkg.sv
// Constants, types and small tables for the GPS time to calendar date block.
// Depends on nothing; imported by gtc_tod, gtc_date and the top level.
package gtc_pkg;

    localparam logic [16:0] EPOCH_MJD   = 17'd44244;
    localparam logic [26:0] MS_PER_DAY  = 27'd86400000;
    localparam logic [21:0] MS_PER_HOUR = 22'd3600000;
    localparam logic [15:0] MS_PER_MIN  = 16'd60000;
    localparam logic [12:0] YR_DIV      = 13'd7305;
    localparam logic [18:0] E_DIV       = 19'd306001;
    localparam logic [13:0] BD_SCALE    = 14'd10000;
    localparam logic [12:0] YEAR_BASE   = 13'd4715;
    // 20 * (MJD offset to the shifted day count) - 2442, and the offset itself.
    localparam logic [25:0] X_OFFSET    = 26'd48028318;
    localparam logic [21:0] B_OFFSET    = 22'd2401538;

    // Reciprocals for exact constant division: the estimate is low by at most one.
    localparam int DAY_SHIFT = 50;
    localparam int HR_SHIFT  = 48;
    localparam int MN_SHIFT  = 40;
    localparam int YR_SHIFT  = 38;
    localparam int E_SHIFT   = 40;
    localparam logic [23:0] DAY_RECIP = 24'((64'd1 << DAY_SHIFT) / 64'd86400000);
    localparam logic [26:0] HR_RECIP  = 27'((64'd1 << HR_SHIFT) / 64'd3600000);
    localparam logic [24:0] MN_RECIP  = 25'((64'd1 << MN_SHIFT) / 64'd60000);
    localparam logic [25:0] YR_RECIP  = 26'((64'd1 << YR_SHIFT) / 64'd7305);
    localparam logic [21:0] E_RECIP   = 22'((64'd1 << E_SHIFT) / 64'd306001);

    // Time-of-day results are ready ahead of the date path
    // and wait in a delay line to line up with it.
    localparam int TOD_DLY  = 5;
    localparam int DATE_LAT = 8;

    typedef struct packed {
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [15:0] second_ms;
    } t_tod;

    typedef struct packed {
        logic [16:0] mjd;
        logic [2:0]  wday;
    } t_side;

    // floor(30.6001 * e) for the month index e.
    function automatic logic [8:0] month_floor(input logic [4:0] e);
        logic [8:0] v;
        case (e)
            5'd1:    v = 9'd30;
            5'd2:    v = 9'd61;
            5'd3:    v = 9'd91;
            5'd4:    v = 9'd122;
            5'd5:    v = 9'd153;
            5'd6:    v = 9'd183;
            5'd7:    v = 9'd214;
            5'd8:    v = 9'd244;
            5'd9:    v = 9'd275;
            5'd10:   v = 9'd306;
            5'd11:   v = 9'd336;
            5'd12:   v = 9'd367;
            5'd13:   v = 9'd397;
            5'd14:   v = 9'd428;
            5'd15:   v = 9'd459;
            5'd16:   v = 9'd489;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

endpackage

FILE: hdl/gtc_tod.sv
// Time-of-day splitter: millisecond of day into hour, minute and millisecond of minute.
// Depends on gtc_pkg; fully pipelined, no stall.
module gtc_tod (
    input  logic          i_clk,
    input  logic [26:0]   i_msd,
    output gtc_pkg::t_tod o_tod
);
    import gtc_pkg::*;

    logic [53:0] n_hprod;
    logic [26:0] n_hrem;
    logic        n_hfix;
    logic [46:0] n_mprod;
    logic [21:0] n_mrem;
    logic        n_mfix;

    logic [4:0]  r1_hq;
    logic [26:0] r1_msd;
    logic [4:0]  r2_hour;
    logic [21:0] r2_remh;
    logic [5:0]  r3_mq;
    logic [21:0] r3_remh;
    logic [4:0]  r3_hour;
    t_tod        r4_tod;

    always_comb begin
        n_hprod = 54'(i_msd) * 54'(HR_RECIP);
        n_hrem  = r1_msd - 27'(r1_hq) * 27'(MS_PER_HOUR);
        n_hfix  = (n_hrem >= 27'(MS_PER_HOUR));
        n_mprod = 47'(r2_remh) * 47'(MN_RECIP);
        n_mrem  = r3_remh - 22'(r3_mq) * 22'(MS_PER_MIN);
        n_mfix  = (n_mrem >= 22'(MS_PER_MIN));
    end

    always_ff @(posedge i_clk) begin
        r1_hq   <= n_hprod[HR_SHIFT+4:HR_SHIFT];
        r1_msd  <= i_msd;
        r2_hour <= n_hfix ? r1_hq + 5'd1 : r1_hq;
        r2_remh <= 22'(n_hfix ? n_hrem - 27'(MS_PER_HOUR) : n_hrem);
        r3_mq   <= n_mprod[MN_SHIFT+5:MN_SHIFT];
        r3_remh <= r2_remh;
        r3_hour <= r2_hour;
        r4_tod.hour      <= r3_hour;
        r4_tod.minute    <= n_mfix ? r3_mq + 6'd1 : r3_mq;
        r4_tod.second_ms <= 16'(n_mfix ? n_mrem - 22'(MS_PER_MIN) : n_mrem);
    end

    assign o_tod = r4_tod;

endmodule

FILE: hdl/gtc_date.sv
// Day number to Gregorian year, month and day, pipelined over eight stages.
// Depends on gtc_pkg; carries the MJD and weekday alongside with the valid bit.
module gtc_date (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [16:0] i_mjd,
    input  logic [2:0]  i_wday,
    output logic        o_valid,
    output logic [11:0] o_year,
    output logic [3:0]  o_month,
    output logic [4:0]  o_day,
    output logic [2:0]  o_wday,
    output logic [16:0] o_mjd
);
    import gtc_pkg::*;

    logic [25:0] n_x;
    logic [51:0] n_cprod;
    logic [25:0] n_crem;
    logic [23:0] n_d;
    logic [22:0] n_xe;
    logic [44:0] n_eprod;
    logic [23:0] n_erem;
    logic [3:0]  n_m;

    logic [DATE_LAT-1:0] r_v;
    t_side               r_side [DATE_LAT];

    logic [25:0] r1_x;
    logic [21:0] r1_b;
    logic [12:0] r2_cq;
    logic [25:0] r2_x;
    logic [21:0] r2_b;
    logic [12:0] r3_c;
    logic [21:0] r3_b;
    logic [8:0]  r4_bd;
    logic [12:0] r4_c;
    logic [22:0] r5_xe;
    logic [8:0]  r5_bd;
    logic [12:0] r5_c;
    logic [4:0]  r6_eq;
    logic [22:0] r6_xe;
    logic [8:0]  r6_bd;
    logic [12:0] r6_c;
    logic [4:0]  r7_e;
    logic [8:0]  r7_bd;
    logic [12:0] r7_c;
    logic [11:0] r8_year;
    logic [3:0]  r8_month;
    logic [4:0]  r8_day;

    always_comb begin
        n_x     = 26'({i_mjd, 4'b0000}) + 26'({i_mjd, 2'b00}) + X_OFFSET;
        n_cprod = 52'(r1_x) * 52'(YR_RECIP);
        n_crem  = r2_x - 26'(r2_cq) * 26'(YR_DIV);
        n_d     = (24'(r3_c) * 24'd1461) >> 2;
        n_xe    = 23'(r4_bd) * 23'(BD_SCALE);
        n_eprod = 45'(r5_xe) * 45'(E_RECIP);
        n_erem  = 24'(r6_xe) - 24'(r6_eq) * 24'(E_DIV);
        n_m     = (r7_e < 5'd14) ? 4'(r7_e - 5'd1) : 4'(r7_e - 5'd13);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[DATE_LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_side[0] <= '{mjd: i_mjd, wday: i_wday};
        for (int k = 1; k < DATE_LAT; k++) begin
            r_side[k] <= r_side[k-1];
        end

        r1_x  <= n_x;
        r1_b  <= 22'(i_mjd) + B_OFFSET;
        r2_cq <= n_cprod[YR_SHIFT+12:YR_SHIFT];
        r2_x  <= r1_x;
        r2_b  <= r1_b;
        r3_c  <= (n_crem >= 26'(YR_DIV)) ? r2_cq + 13'd1 : r2_cq;
        r3_b  <= r2_b;
        // The remainder of the year split always lands between 123 and 488.
        r4_bd <= 9'(r3_b - 22'(n_d));
        r4_c  <= r3_c;
        r5_xe <= n_xe;
        r5_bd <= r4_bd;
        r5_c  <= r4_c;
        r6_eq <= n_eprod[E_SHIFT+4:E_SHIFT];
        r6_xe <= r5_xe;
        r6_bd <= r5_bd;
        r6_c  <= r5_c;
        r7_e  <= (n_erem >= 24'(E_DIV)) ? r6_eq + 5'd1 : r6_eq;
        r7_bd <= r6_bd;
        r7_c  <= r6_c;
        r8_month <= n_m;
        r8_day   <= 5'(r7_bd - month_floor(r7_e));
        r8_year  <= 12'(r7_c - YEAR_BASE - 13'(n_m >= 4'd3));
    end

    assign o_valid = r_v[DATE_LAT-1];
    assign o_year  = r8_year;
    assign o_month = r8_month;
    assign o_day   = r8_day;
    assign o_wday  = r_side[DATE_LAT-1].wday;
    assign o_mjd   = r_side[DATE_LAT-1].mjd;

endmodule

FILE: hdl/gps_time_to_calendar_date.sv
// Top level of the GPS week and time of week to calendar date converter.
// Depends on gtc_pkg, gtc_tod, gtc_date and the assertion macro header.
`include "gps_time_to_calendar_date_assert.svh"

// A word is taken on every clock edge where start is high and busy is low, one word
// per cycle with no gaps needed. Its result is on the o_ ports for a single cycle,
// flagged by o_valid, once the word has passed the r1_, r2_, r3_ registers and gtc_date.
// Each constant division is a reciprocal multiply followed by a one-step correction,
// and the date path chains three of those. The receiver cannot hold results off, so
// nothing ever backs up; busy is set while reset is applied and clears at the clock
// edge after its release.
module gps_time_to_calendar_date (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [12:0] i_gps_week,
    input  logic [29:0] i_week_time_ms,
    output logic        o_valid,
    output logic [11:0] o_year,
    output logic [3:0]  o_month,
    output logic [4:0]  o_day,
    output logic [4:0]  o_hour,
    output logic [5:0]  o_minute,
    output logic [15:0] o_second_ms,
    output logic [2:0]  o_weekday,
    output logic [16:0] o_mjd_day
);
    import gtc_pkg::*;

    logic        w_accept;
    logic [53:0] n1_prod;
    logic [16:0] n1_base;
    logic [30:0] n2_rem;
    logic        n2_fix;
    logic [4:0]  n3_s;
    logic [2:0]  n3_wday;
    t_tod        w_tod;

    logic        r_busy;
    logic        r1_v;
    logic [3:0]  r1_dq;
    logic [29:0] r1_tow;
    logic [16:0] r1_base;
    logic        r2_v;
    logic [3:0]  r2_days;
    logic [26:0] r2_msd;
    logic [16:0] r2_base;
    logic        r3_v;
    logic [16:0] r3_mjd;
    logic [2:0]  r3_wday;
    t_tod        r_tod_dly [TOD_DLY];

    assign w_accept = start & ~r_busy;
    assign busy     = r_busy;

    always_comb begin
        n1_prod = 54'(i_week_time_ms) * 54'(DAY_RECIP);
        n1_base = EPOCH_MJD + 17'(i_gps_week) * 17'd7;
        n2_rem  = 31'(r1_tow) - 31'(r1_dq) * 31'(MS_PER_DAY);
        n2_fix  = (n2_rem >= 31'(MS_PER_DAY));
        // The Julian day number is 6 plus the day carry, modulo 7, ahead of the week.
        n3_s    = 5'(r2_days) + 5'd6;
        if (n3_s >= 5'd14) begin
            n3_wday = 3'(n3_s - 5'd14);
        end else if (n3_s >= 5'd7) begin
            n3_wday = 3'(n3_s - 5'd7);
        end else begin
            n3_wday = 3'(n3_s);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r1_v   <= 1'b0;
            r2_v   <= 1'b0;
            r3_v   <= 1'b0;
        end else begin
            r_busy <= 1'b0;
            r1_v   <= w_accept;
            r2_v   <= r1_v;
            r3_v   <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_dq   <= n1_prod[DAY_SHIFT+3:DAY_SHIFT];
        r1_tow  <= i_week_time_ms;
        r1_base <= n1_base;
        r2_days <= n2_fix ? r1_dq + 4'd1 : r1_dq;
        r2_msd  <= 27'(n2_fix ? n2_rem - 31'(MS_PER_DAY) : n2_rem);
        r2_base <= r1_base;
        r3_mjd  <= r2_base + 17'(r2_days);
        r3_wday <= n3_wday + 3'd1;
        r_tod_dly[0] <= w_tod;
        for (int k = 1; k < TOD_DLY; k++) begin
            r_tod_dly[k] <= r_tod_dly[k-1];
        end
    end

    gtc_tod u_tod (
        .i_clk (i_clk),
        .i_msd (r2_msd),
        .o_tod (w_tod)
    );

    gtc_date u_date (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r3_v),
        .i_mjd   (r3_mjd),
        .i_wday  (r3_wday),
        .o_valid (o_valid),
        .o_year  (o_year),
        .o_month (o_month),
        .o_day   (o_day),
        .o_wday  (o_weekday),
        .o_mjd   (o_mjd_day)
    );

    assign o_hour      = r_tod_dly[TOD_DLY-1].hour;
    assign o_minute    = r_tod_dly[TOD_DLY-1].minute;
    assign o_second_ms = r_tod_dly[TOD_DLY-1].second_ms;

    `GTC_ASSERT_IMPL(a_latency, i_clk, i_rst_n, w_accept, ##11 o_valid)
    `GTC_ASSERT_IMPL(a_no_extra, i_clk, i_rst_n, o_valid, $past(w_accept, 11))
    `GTC_ASSERT_IMPL(a_tod_range, i_clk, i_rst_n, o_valid, (o_hour <= 5'd23) && (o_minute <= 6'd59) && (o_second_ms <= 16'd59999))
    `GTC_ASSERT_IMPL(a_date_range, i_clk, i_rst_n, o_valid, (o_month >= 4'd1) && (o_month <= 4'd12) && (o_day >= 5'd1) && (o_day <= 5'd31))
    `GTC_ASSERT_NEXT(a_busy_clear, i_clk, i_rst_n, i_rst_n, !busy)

endmodule

FILE: tb/sv/gps_time_to_calendar_date_tb.sv
// Self-checking testbench for gps_time_to_calendar_date: directed table, then random words.
// Every accepted word is predicted by its typed date or a local calendar model and checked when o_valid fires.
// Depends only on the RTL of gps_time_to_calendar_date.
`timescale 1ns / 1ps

module gps_time_to_calendar_date_tb;

    localparam longint unsigned EPOCH_MJD   = 64'd44244;
    localparam longint unsigned MS_DAY      = 64'd86400000;
    localparam longint unsigned MS_HOUR     = 64'd3600000;
    localparam longint unsigned MS_MIN      = 64'd60000;
    localparam longint unsigned MJD_TO_JDN  = 64'd2400001;
    localparam longint unsigned WEEK_MS     = 64'd604800000;
    localparam int              PIPE_DEPTH  = 11;
    localparam int              RANDOM_WORDS = 1050;
    localparam int              CYCLE_LIMIT = 60000;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [15:0] second_ms;
        logic [2:0]  weekday;
        logic [16:0] mjd_day;
    } t_cal_date;

    typedef struct {
        logic [12:0] week;
        logic [29:0] tow;
        bit          typed;
        t_cal_date   date;
    } t_date_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [12:0] i_gps_week;
    logic [29:0] i_week_time_ms;
    logic        o_valid;
    logic [11:0] o_year;
    logic [3:0]  o_month;
    logic [4:0]  o_day;
    logic [4:0]  o_hour;
    logic [5:0]  o_minute;
    logic [15:0] o_second_ms;
    logic [2:0]  o_weekday;
    logic [16:0] o_mjd_day;

    // Typed expectation that travels with the word currently on the inputs.
    bit          word_typed;
    t_cal_date   word_date;

    t_cal_date   pending_dates[$];
    t_date_row   date_rows[$];
    int          mismatch_count = 0;
    int          cycle_count = 0;

    gps_time_to_calendar_date u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_gps_week     (i_gps_week),
        .i_week_time_ms (i_week_time_ms),
        .o_valid        (o_valid),
        .o_year         (o_year),
        .o_month        (o_month),
        .o_day          (o_day),
        .o_hour         (o_hour),
        .o_minute       (o_minute),
        .o_second_ms    (o_second_ms),
        .o_weekday      (o_weekday),
        .o_mjd_day      (o_mjd_day)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_cal_date calendar_of(input logic [12:0] week, input logic [29:0] tow);
        t_cal_date       r;
        longint unsigned mjd, msd, jdn, b, c, d, e, m, dy, yr;
        mjd = EPOCH_MJD + 64'd7 * 64'(week) + 64'(tow) / MS_DAY;
        msd = 64'(tow) % MS_DAY;
        jdn = mjd + MJD_TO_JDN;
        // Julian day to Gregorian with the fractional constants scaled to integers.
        b  = jdn + 64'd1537;
        c  = (64'd20 * b - 64'd2442) / 64'd7305;
        d  = (64'd1461 * c) / 64'd4;
        e  = (64'd10000 * (b - d)) / 64'd306001;
        dy = b - d - (64'd306001 * e) / 64'd10000;
        m  = e - 64'd1 - 64'd12 * (e / 64'd14);
        yr = c - 64'd4715 - (64'd7 + m) / 64'd10;
        r.year      = yr[11:0];
        r.month     = m[3:0];
        r.day       = dy[4:0];
        r.hour      = 5'(msd / MS_HOUR);
        r.minute    = 6'((msd % MS_HOUR) / MS_MIN);
        r.second_ms = 16'(msd % MS_MIN);
        r.weekday   = 3'(jdn % 64'd7 + 64'd1);
        r.mjd_day   = mjd[16:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want) report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    // Result checking and prediction share one block so their order within an edge is fixed.
    always @(posedge i_clk) begin
        t_cal_date want;
        if (i_rst_n) begin
            if (o_valid) begin
                if (pending_dates.size() == 0) begin
                    report_mismatch("result word with nothing expected");
                end else begin
                    want = pending_dates.pop_front();
                    check_field("year", o_year, want.year);
                    check_field("month", o_month, want.month);
                    check_field("day", o_day, want.day);
                    check_field("hour", o_hour, want.hour);
                    check_field("minute", o_minute, want.minute);
                    check_field("second_ms", o_second_ms, want.second_ms);
                    check_field("weekday", o_weekday, want.weekday);
                    check_field("mjd_day", o_mjd_day, want.mjd_day);
                end
            end
            if (start && !busy) begin
                if (word_typed) pending_dates.push_back(word_date);
                else pending_dates.push_back(calendar_of(i_gps_week, i_week_time_ms));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic send_word(input logic [12:0] week, input logic [29:0] tow, input bit typed,
                             input t_cal_date date, input bit may_idle);
        while (may_idle && $urandom_range(99) < 9) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start          <= 1'b1;
        i_gps_week     <= week;
        i_week_time_ms <= tow;
        word_typed     <= typed;
        word_date      <= date;
        do @(posedge i_clk); while (busy);
    endtask

    function automatic logic [29:0] random_tow();
        int unsigned pick;
        longint unsigned days;
        pick = $urandom_range(99);
        if (pick < 80) return 30'($urandom_range(604799999, 0));
        if (pick < 90) return 30'($urandom);
        // Land close to a day boundary, on either side.
        days = $urandom_range(12, 1);
        return 30'(days * MS_DAY - 64'd2 + 64'($urandom_range(3)));
    endfunction

    initial begin
        logic [12:0] week;
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_gps_week     = '0;
        i_week_time_ms = '0;
        word_typed     = 1'b0;
        word_date      = '0;

        // Rows with a date typed in are the epoch, day and week edges, and the largest time of week.
        date_rows.push_back('{13'd0, 30'd0, 1'b1,
                              '{12'd1980, 4'd1, 5'd6, 5'd0, 6'd0, 16'd0, 3'd7, 17'd44244}});
        date_rows.push_back('{13'd0, 30'd86399999, 1'b1,
                              '{12'd1980, 4'd1, 5'd6, 5'd23, 6'd59, 16'd59999, 3'd7, 17'd44244}});
        date_rows.push_back('{13'd0, 30'd86400000, 1'b1,
                              '{12'd1980, 4'd1, 5'd7, 5'd0, 6'd0, 16'd0, 3'd1, 17'd44245}});
        date_rows.push_back('{13'd0, 30'd604799999, 1'b1,
                              '{12'd1980, 4'd1, 5'd12, 5'd23, 6'd59, 16'd59999, 3'd6, 17'd44250}});
        date_rows.push_back('{13'd1, 30'd0, 1'b1,
                              '{12'd1980, 4'd1, 5'd13, 5'd0, 6'd0, 16'd0, 3'd7, 17'd44251}});
        // A time of week of exactly one week rolls into the next week.
        date_rows.push_back('{13'd0, 30'd604800000, 1'b1,
                              '{12'd1980, 4'd1, 5'd13, 5'd0, 6'd0, 16'd0, 3'd7, 17'd44251}});
        date_rows.push_back('{13'd0, 30'h3FFFFFFF, 1'b1,
                              '{12'd1980, 4'd1, 5'd18, 5'd10, 6'd15, 16'd41823, 3'd5, 17'd44256}});
        date_rows.push_back('{13'd8191, 30'd0, 1'b0, '0});
        date_rows.push_back('{13'd8191, 30'd604799999, 1'b0, '0});
        date_rows.push_back('{13'd8191, 30'h3FFFFFFF, 1'b0, '0});
        date_rows.push_back('{13'd100, 30'd59999, 1'b0, '0});
        date_rows.push_back('{13'd100, 30'd60000, 1'b0, '0});
        date_rows.push_back('{13'd100, 30'd3599999, 1'b0, '0});
        date_rows.push_back('{13'd100, 30'd3600000, 1'b0, '0});
        date_rows.push_back('{13'd51, 30'd345599999, 1'b0, '0});
        date_rows.push_back('{13'd51, 30'd345600000, 1'b0, '0});
        date_rows.push_back('{13'd1024, 30'd0, 1'b0, '0});
        date_rows.push_back('{13'd1051, 30'd86399999, 1'b0, '0});
        date_rows.push_back('{13'd1051, 30'd172800000, 1'b0, '0});
        date_rows.push_back('{13'd6269, 30'd86399999, 1'b0, '0});
        date_rows.push_back('{13'd6269, 30'd86400000, 1'b0, '0});
        date_rows.push_back('{13'h1555, 30'h2AAAAAAA, 1'b0, '0});
        date_rows.push_back('{13'h0AAA, 30'h15555555, 1'b0, '0});

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (date_rows[i])
            send_word(date_rows[i].week, date_rows[i].tow, date_rows[i].typed,
                      date_rows[i].date, 1'b1);

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            week = 13'($urandom_range(8191, 0));
            // Words 400 to 699 go in back to back.
            send_word(week, random_tow(), 1'b0, '0, !(n >= 400 && n < 700));
        end
        start <= 1'b0;

        while (pending_dates.size() != 0) @(posedge i_clk);
        repeat (2 * PIPE_DEPTH) @(posedge i_clk);

        if (mismatch_count == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hdl
hdl/gtc_pkg.sv
hdl/gtc_tod.sv
hdl/gtc_date.sv
hdl/gps_time_to_calendar_date.sv
tb/sv/gps_time_to_calendar_date_tb.sv
